// ----- rtl/bracket_nesting_checker_unit_macros.svh -----
// Assertion shorthands used by the stack engine (bnc_back)
`ifndef BRACKET_NESTING_CHECKER_UNIT_MACROS_SVH
`define BRACKET_NESTING_CHECKER_UNIT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define BNC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BNC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/bnc_pkg.sv -----
`timescale 1ns / 1ps
package bnc_pkg;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   localparam logic [7:0] OPEN_CHARS [4]  = '{8'h28, 8'h5B, 8'h7B, 8'h3C};
   localparam logic [7:0] CLOSE_CHARS [4] = '{8'h29, 8'h5D, 8'h7D, 8'h3E};

   typedef enum logic [2:0] {
      STAT_ACCEPTED   = 3'd0,
      STAT_MISMATCH   = 3'd1,
      STAT_UNMATCHED  = 3'd2,
      STAT_OVERFLOW   = 3'd3,
      STAT_IGNORED    = 3'd4,
      STAT_COMPLETION = 3'd5
   } status_type;

   // classified item, front to back
   typedef struct packed {
      logic [7:0] sym;
      logic       line_end;
      logic       is_open;
      logic       is_close;
      logic [1:0] kind;
   } op_type;

   typedef struct packed {
      status_type status;
      logic [7:0] expected;
      logic [7:0] found;
      logic [5:0] depth;
      logic       last;
   } result_type;

   function automatic op_type classify(logic [7:0] sym, logic line_end);
      op_type op;
      op = '0;
      op.sym = sym;
      op.line_end = line_end;
      for (int k = 0; k < 4; k++) begin
         if (sym == OPEN_CHARS[k]) begin
            op.is_open = 1'b1;
            op.kind = 2'(k);
         end
         if (sym == CLOSE_CHARS[k]) begin
            op.is_close = 1'b1;
            op.kind = 2'(k);
         end
      end
      return op;
   endfunction

   function automatic logic [7:0] close_char(logic [1:0] kind);
      return CLOSE_CHARS[kind];
   endfunction

endpackage

// ----- rtl/bnc_front.sv -----
`timescale 1ns / 1ps
module bnc_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  logic [7:0]      req_symbol,
   input  logic            req_line_end,
   output logic            full,
   output bnc_pkg::op_type op,
   output logic            op_valid,
   input  logic            op_take
);
   import bnc_pkg::*;

   op_type               queue_mem [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 wr;
   logic                 rd;

   assign full     = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign wr       = push && !full;
   assign op_valid = (count_ff != '0);
   assign rd       = op_take && op_valid;
   assign op       = queue_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + Q_CNT_W'(wr) - Q_CNT_W'(rd);
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         queue_mem[wr_ptr_ff] <= classify(req_symbol, req_line_end);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/bnc_back.sv -----
`timescale 1ns / 1ps
module bnc_back #(
   parameter int STACK_DEPTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  bnc_pkg::op_type     op,
   input  logic                op_valid,
   output logic                op_take,
   input  logic                res_full,
   output logic                res_wr,
   output bnc_pkg::result_type res
);
   import bnc_pkg::*;
   `include "bracket_nesting_checker_unit_macros.svh"

   localparam int SP_W   = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   typedef enum logic [1:0] {
      BK_RUN   = 2'b01,
      BK_DRAIN = 2'b10
   } back_state_type;

   back_state_type    state_ff, state_in;
   logic [SP_W-1:0]   sp_ff, sp_in;
   logic              corrupt_ff, corrupt_in;
   logic [7:0]        found_ff, found_in;

   logic [1:0]        stack_mem [STACK_DEPTH];
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [SP_W-1:0]   sp_rd;
   logic [1:0]        rd_data_ff;
   logic              byp_ff;
   logic [1:0]        byp_data_ff;
   logic [1:0]        top;

   logic [SP_W-1:0]   sp_new;
   logic              corr_new;
   logic              line_done;

   // top of stack: registered read of entry sp-1, with the just-pushed kind forwarded
   assign top = byp_ff ? byp_data_ff : rd_data_ff;

   always_comb begin
      state_in   = state_ff;
      sp_in      = sp_ff;
      corrupt_in = corrupt_ff;
      found_in   = found_ff;
      wr_en      = 1'b0;
      wr_addr    = sp_ff[ADDR_W-1:0];
      op_take    = 1'b0;
      res_wr     = 1'b0;
      res        = '0;
      sp_new     = sp_ff;
      corr_new   = corrupt_ff;
      line_done  = 1'b0;
      case (state_ff)
         BK_RUN: begin
            if (op_valid && !res_full) begin
               op_take      = 1'b1;
               res_wr       = 1'b1;
               res.status   = STAT_IGNORED;
               res.found    = op.sym;
               if (corrupt_ff) begin
                  // rest of a corrupt line is skipped
               end else if (op.is_open) begin
                  if (sp_ff == SP_W'(STACK_DEPTH)) begin
                     res.status = STAT_OVERFLOW;
                     corr_new   = 1'b1;
                  end else begin
                     wr_en      = 1'b1;
                     sp_new     = sp_ff + 1'b1;
                     res.status = STAT_ACCEPTED;
                  end
               end else if (op.is_close) begin
                  if (sp_ff == '0) begin
                     res.status = STAT_UNMATCHED;
                     corr_new   = 1'b1;
                  end else begin
                     sp_new = sp_ff - 1'b1;
                     if (top == op.kind) begin
                        res.status = STAT_ACCEPTED;
                     end else begin
                        res.status   = STAT_MISMATCH;
                        res.expected = close_char(top);
                        corr_new     = 1'b1;
                     end
                  end
               end
               if (!op.line_end) begin
                  res.depth  = 6'(sp_new);
                  sp_in      = sp_new;
                  corrupt_in = corr_new;
               end else if (!corr_new && sp_new != '0) begin
                  res.depth  = 6'(sp_new);
                  sp_in      = sp_new;
                  corrupt_in = 1'b0;
                  found_in   = op.sym;
                  state_in   = BK_DRAIN;
               end else begin
                  res.last   = 1'b1;
                  sp_in      = '0;
                  corrupt_in = 1'b0;
                  line_done  = 1'b1;
               end
            end
         end
         BK_DRAIN: begin
            if (!res_full) begin
               res_wr       = 1'b1;
               sp_in        = sp_ff - 1'b1;
               res.status   = STAT_COMPLETION;
               res.expected = close_char(top);
               res.found    = found_ff;
               res.depth    = 6'(sp_in);
               res.last     = (sp_in == '0);
               if (sp_in == '0) begin
                  state_in = BK_RUN;
               end
            end
         end
         default: begin
            state_in = BK_RUN;
         end
      endcase
   end

   assign sp_rd   = sp_in - 1'b1;
   assign rd_addr = sp_rd[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= op.kind;
      end
      rd_data_ff  <= stack_mem[rd_addr];
      byp_ff      <= wr_en && (wr_addr == rd_addr);
      byp_data_ff <= op.kind;
      found_ff    <= found_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_RUN;
         sp_ff      <= '0;
         corrupt_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sp_ff      <= sp_in;
         corrupt_ff <= corrupt_in;
      end
   end

   `BNC_ASSERT_NOW(a_sp_range, 1'b1, sp_ff <= SP_W'(STACK_DEPTH), "stack pointer past depth")
   `BNC_ASSERT_NOW(a_drain_nonempty, state_ff == BK_DRAIN, sp_ff != '0 && !corrupt_ff, "drain on empty stack")
   `BNC_ASSERT_NEXT(a_line_clear, line_done, sp_ff == '0 && !corrupt_ff, "line state not cleared")
   `BNC_ASSERT_NEXT(a_drain_exit, res_wr && res.status == STAT_COMPLETION && res.last, state_ff == BK_RUN, "drain did not end")

endmodule

// ----- rtl/bnc_result_queue.sv -----
`timescale 1ns / 1ps
module bnc_result_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                res_wr,
   input  bnc_pkg::result_type res,
   output logic                res_full,
   output logic                empty,
   input  logic                pop,
   output logic [2:0]          rsp_status,
   output logic [7:0]          rsp_expected,
   output logic [7:0]          rsp_found,
   output logic [5:0]          rsp_depth,
   output logic                rsp_last
);
   import bnc_pkg::*;

   result_type           queue_mem [Q_DEPTH];
   result_type           head;
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 wr;
   logic                 rd;

   assign res_full = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign empty    = (count_ff == '0);
   assign wr       = res_wr && !res_full;
   assign rd       = pop && !empty;

   assign head         = queue_mem[rd_ptr_ff];
   assign rsp_status   = head.status;
   assign rsp_expected = head.expected;
   assign rsp_found    = head.found;
   assign rsp_depth    = head.depth;
   assign rsp_last     = head.last;

   always_comb begin
      wr_ptr_in = wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + Q_CNT_W'(wr) - Q_CNT_W'(rd);
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         queue_mem[wr_ptr_ff] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/bracket_nesting_checker_unit.sv -----
// The stack engine writes an item's first result to the result queue as it takes it.
// One item per cycle while the result queue has room; a clean line end with N
// openers left stalls intake while completion closers are popped from the stack memory.
// Reset (synchronous) empties both queues and clears the stack pointer and corrupt flag;
// stack contents are not cleared, and no entry above the pointer is ever used.
`timescale 1ns / 1ps
module bracket_nesting_checker_unit #(
   parameter int STACK_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_symbol,
   input  logic       req_line_end,
   output logic       empty,
   input  logic       pop,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_expected,
   output logic [7:0] rsp_found,
   output logic [5:0] rsp_depth,
   output logic       rsp_last
);
   import bnc_pkg::*;

   op_type     op;
   logic       op_valid;
   logic       op_take;
   logic       res_full;
   logic       res_wr;
   result_type res;

   bnc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .req_symbol   (req_symbol),
      .req_line_end (req_line_end),
      .full         (full),
      .op           (op),
      .op_valid     (op_valid),
      .op_take      (op_take)
   );

   bnc_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .op       (op),
      .op_valid (op_valid),
      .op_take  (op_take),
      .res_full (res_full),
      .res_wr   (res_wr),
      .res      (res)
   );

   bnc_result_queue u_result_queue (
      .clock        (clock),
      .reset        (reset),
      .res_wr       (res_wr),
      .res          (res),
      .res_full     (res_full),
      .empty        (empty),
      .pop          (pop),
      .rsp_status   (rsp_status),
      .rsp_expected (rsp_expected),
      .rsp_found    (rsp_found),
      .rsp_depth    (rsp_depth),
      .rsp_last     (rsp_last)
   );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
   import bnc_pkg::*;

   localparam int STACK_LIMIT = 32;
   localparam int ITEM_TARGET = 370;
   localparam int CYCLE_LIMIT = 1_000_000;

   typedef enum {
      LINE_NESTED,
      LINE_BROKEN,
      LINE_STRAY,
      LINE_DEEP,
      LINE_NOISE
   } line_kind_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic [7:0] req_symbol = 8'h00;
   logic       req_line_end = 1'b0;
   logic       pop = 1'b0;
   logic       full;
   logic       empty;
   logic [2:0] rsp_status;
   logic [7:0] rsp_expected;
   logic [7:0] rsp_found;
   logic [5:0] rsp_depth;
   logic       rsp_last;

   bracket_nesting_checker_unit #(
      .STACK_DEPTH(STACK_LIMIT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_symbol(req_symbol),
      .req_line_end(req_line_end),
      .empty(empty),
      .pop(pop),
      .rsp_status(rsp_status),
      .rsp_expected(rsp_expected),
      .rsp_found(rsp_found),
      .rsp_depth(rsp_depth),
      .rsp_last(rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Tracks the opener stack per line and holds the results still owed.
   class bracket_scoreboard;
      logic [1:0]  opener_kinds [STACK_LIMIT];
      int unsigned nest_level;
      bit          skipping;
      result_type  awaited [$];
      int unsigned mismatches;
      int unsigned compared;
      int unsigned items;

      task report(string msg);
         $display("tb: mismatch on result %0d: %s", compared, msg);
         mismatches++;
      endtask

      function void note_item(logic [7:0] sym, logic line_end);
         int         open_k;
         int         close_k;
         status_type st;
         logic [7:0] want_close;
         result_type r;
         open_k = -1;
         close_k = -1;
         st = STAT_IGNORED;
         want_close = 8'h00;
         for (int k = 0; k < 4; k++) begin
            if (sym == OPEN_CHARS[k]) open_k = k;
            if (sym == CLOSE_CHARS[k]) close_k = k;
         end
         items++;
         if (skipping) begin
            st = STAT_IGNORED;
         end else if (open_k >= 0) begin
            if (nest_level >= STACK_LIMIT) begin
               st = STAT_OVERFLOW;
               skipping = 1'b1;
            end else begin
               opener_kinds[nest_level] = 2'(open_k);
               nest_level++;
               st = STAT_ACCEPTED;
            end
         end else if (close_k >= 0) begin
            if (nest_level == 0) begin
               st = STAT_UNMATCHED;
               skipping = 1'b1;
            end else begin
               nest_level--;
               if (opener_kinds[nest_level] == 2'(close_k)) begin
                  st = STAT_ACCEPTED;
               end else begin
                  st = STAT_MISMATCH;
                  want_close = CLOSE_CHARS[opener_kinds[nest_level]];
                  skipping = 1'b1;
               end
            end
         end
         r.status = st;
         r.expected = want_close;
         r.found = sym;
         r.depth = 6'(nest_level);
         r.last = 1'b0;
         if (!line_end) begin
            awaited.push_back(r);
         end else begin
            if (!skipping && nest_level > 0) begin
               awaited.push_back(r);
               // completion closers come out innermost first
               while (nest_level > 0) begin
                  nest_level--;
                  r.status = STAT_COMPLETION;
                  r.expected = CLOSE_CHARS[opener_kinds[nest_level]];
                  r.depth = 6'(nest_level);
                  r.last = (nest_level == 0);
                  awaited.push_back(r);
               end
            end else begin
               r.depth = 6'd0;
               r.last = 1'b1;
               awaited.push_back(r);
            end
            nest_level = 0;
            skipping = 1'b0;
         end
      endfunction

      task check_result(result_type got);
         result_type want;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected item, status %0d found 0x%02h",
                             got.status, got.found));
            return;
         end
         want = awaited.pop_front();
         compared++;
         if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.expected !== want.expected)
            report($sformatf("expected 0x%02h, want 0x%02h", got.expected, want.expected));
         if (got.found !== want.found)
            report($sformatf("found 0x%02h, want 0x%02h", got.found, want.found));
         if (got.depth !== want.depth)
            report($sformatf("depth %0d, want %0d", got.depth, want.depth));
         if (got.last !== want.last)
            report($sformatf("last %0b, want %0b", got.last, want.last));
      endtask
   endclass

   bracket_scoreboard sb = new();
   logic [7:0]  line_buf [$];
   bit          in_calm = 1'b0;
   bit          out_calm = 1'b0;
   bit          draining = 1'b0;
   int unsigned lines_sent = 0;
   int unsigned deep_lines = 0;
   int unsigned cycles = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: timed out after %0d cycles", cycles);
         $display("[bracket_nesting_checker_unit] ERROR");
         $finish;
      end
   end

   // called at a rising edge; returns at the edge where the item is taken
   task send_item(input logic [7:0] sym, input logic line_end);
      int gap;
      gap = in_calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_symbol <= sym;
      req_line_end <= line_end;
      push <= 1'b1;
      @(posedge clock);
      while (full !== 1'b0) @(posedge clock);
      sb.note_item(sym, line_end);
   endtask

   task send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1);
      lines_sent++;
   endtask

   task send_line();
      for (int i = 0; i < line_buf.size(); i++) send_item(line_buf[i], i == line_buf.size() - 1);
      lines_sent++;
   endtask

   function logic [7:0] any_bracket();
      int k;
      k = $urandom_range(0, 7);
      return (k < 4) ? OPEN_CHARS[k] : CLOSE_CHARS[k - 4];
   endfunction

   function automatic void build_line(line_kind_type kind);
      logic [1:0] open_q [$];
      int         len;
      int         k;
      line_buf.delete();
      case (kind)
         LINE_NESTED, LINE_BROKEN, LINE_STRAY: begin
            len = $urandom_range(1, 14);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 7) == 0) begin
                  line_buf.push_back(8'($urandom_range(0, 255)));
               end else if (open_q.size() > 0 && $urandom_range(0, 1) == 1) begin
                  line_buf.push_back(CLOSE_CHARS[open_q.pop_back()]);
               end else begin
                  k = $urandom_range(0, 3);
                  open_q.push_back(2'(k));
                  line_buf.push_back(OPEN_CHARS[k]);
               end
            end
            if (kind == LINE_BROKEN) begin
               if (open_q.size() == 0) begin
                  k = $urandom_range(0, 3);
                  open_q.push_back(2'(k));
                  line_buf.push_back(OPEN_CHARS[k]);
               end
               // a closer of any other kind than the top opener
               k = (open_q[$] + $urandom_range(1, 3)) % 4;
               line_buf.push_back(CLOSE_CHARS[k]);
               repeat ($urandom_range(0, 4)) line_buf.push_back(any_bracket());
            end else if (kind == LINE_STRAY) begin
               while (open_q.size() > 0) line_buf.push_back(CLOSE_CHARS[open_q.pop_back()]);
               line_buf.push_back(CLOSE_CHARS[$urandom_range(0, 3)]);
               repeat ($urandom_range(0, 4)) line_buf.push_back(any_bracket());
            end
         end
         LINE_DEEP: begin
            len = $urandom_range(STACK_LIMIT - 4, STACK_LIMIT + 3);
            for (int i = 0; i < len; i++) begin
               k = $urandom_range(0, 3);
               open_q.push_back(2'(k));
               line_buf.push_back(OPEN_CHARS[k]);
            end
            repeat ($urandom_range(0, 3)) line_buf.push_back(CLOSE_CHARS[open_q.pop_back()]);
         end
         default: begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 1) == 1) line_buf.push_back(8'($urandom_range(0, 255)));
               else line_buf.push_back(any_bracket());
            end
         end
      endcase
   endfunction

   // result side: random pop stalls, checked at the accepting edge
   initial begin
      result_type got;
      int         gap;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         gap = (out_calm || draining) ? 0 : $urandom_range(0, 15);
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty !== 1'b0) @(posedge clock);
         got.status = status_type'(rsp_status);
         got.expected = rsp_expected;
         got.found = rsp_found;
         got.depth = rsp_depth;
         got.last = rsp_last;
         sb.check_result(got);
      end
   end

   initial begin
      int            pick;
      line_kind_type kind;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_text("([{<>}])");
      send_text("(]x");
      send_text(")");
      send_text("a{<");
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item("[", 1'b0);
      send_item(">", 1'b0);
      send_item("<", 1'b1);
      lines_sent++;
      send_text("x");

      while (sb.items < ITEM_TARGET) begin
         if ($urandom_range(0, 9) == 0) in_calm = !in_calm;
         if ($urandom_range(0, 9) == 0) out_calm = !out_calm;
         pick = $urandom_range(0, 99);
         if (pick < 45) kind = LINE_NESTED;
         else if (pick < 65) kind = LINE_BROKEN;
         else if (pick < 80) kind = LINE_STRAY;
         else if (pick < 87) kind = LINE_DEEP;
         else kind = LINE_NOISE;
         if (kind == LINE_DEEP) deep_lines++;
         build_line(kind);
         send_line();
      end
      push <= 1'b0;
      draining = 1'b1;

      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("tb: %0d items over %0d lines (%0d pushed near the stack limit)",
               sb.items, lines_sent, deep_lines);
      $display("tb: %0d results compared, %0d mismatches", sb.compared, sb.mismatches);
      if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
         $display("[bracket_nesting_checker_unit] OK");
      end else begin
         $display("[bracket_nesting_checker_unit] ERROR");
      end
      $finish;
   end
endmodule
